[sv/wsw_pkg.sv]
// Shared types, constants and check matrix for the WOM second-write encoder.
package wsw_pkg;

    localparam int CODE_BITS   = 22;
    localparam int FIXED_CELLS = 6;
    localparam int SYN_BITS    = CODE_BITS - FIXED_CELLS;
    localparam int ROW_W       = CODE_BITS + 1;
    localparam int TGT_BIT     = CODE_BITS;
    localparam int COL_W       = $clog2(SYN_BITS + 1);
    localparam int ROW_IDX_W   = $clog2(SYN_BITS);
    localparam int CNT_W       = $clog2(CODE_BITS + 1);

    localparam logic [SYN_BITS-1:0] CHECK_ROWS [CODE_BITS] = '{
        16'hC396, 16'h147A, 16'hD9F8, 16'h57C7, 16'hC7C8, 16'hDD89, 16'h2509, 16'hB19A,
        16'h7B1D, 16'hADF7, 16'h5008, 16'hAACB, 16'h68E4, 16'h9867, 16'hBA7C, 16'hBBCA,
        16'hF2F4, 16'hBB06, 16'hB6F5, 16'hFFE9, 16'h7578, 16'h7F8B
    };

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_MASK = 2'd1,
        ST_SINGULAR = 2'd2
    } t_status;

    typedef struct packed {
        logic                             valid;
        t_status                          status;
        logic [CODE_BITS-1:0]             first;
        logic [CODE_BITS-1:0]             mask;
        logic [COL_W-1:0]                 col;
        logic [SYN_BITS-1:0][ROW_W-1:0]   rows;
    } t_stage;

endpackage

[sv/wsw_setup.sv]
// Front stage: mask check, syndrome, target and augmented matrix build.
module wsw_setup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic [wsw_pkg::SYN_BITS-1:0]  i_value,
    input  logic [wsw_pkg::CODE_BITS-1:0] i_first,
    input  logic [wsw_pkg::CODE_BITS-1:0] i_mask,
    output wsw_pkg::t_stage               o_stage
);

    wsw_pkg::t_stage r_stage;
    wsw_pkg::t_stage n_stage;

    logic [wsw_pkg::CNT_W-1:0]    w_ones;
    logic [wsw_pkg::SYN_BITS-1:0] w_syn;
    logic [wsw_pkg::SYN_BITS-1:0] w_target;

    always_comb begin
        w_ones = '0;
        w_syn  = '0;
        for (int b = 0; b < wsw_pkg::CODE_BITS; b++) begin
            w_ones = w_ones + wsw_pkg::CNT_W'(i_mask[b]);
            if (i_first[b]) begin
                w_syn = w_syn ^ wsw_pkg::CHECK_ROWS[b];
            end
        end
        w_target = i_value ^ w_syn;

        n_stage       = '0;
        n_stage.valid = i_valid;
        n_stage.first = i_first;
        n_stage.mask  = i_mask;
        n_stage.col   = '0;
        if (w_ones != wsw_pkg::CNT_W'(wsw_pkg::FIXED_CELLS) || (i_first & ~i_mask) != '0) begin
            n_stage.status = wsw_pkg::ST_BAD_MASK;
        end else begin
            n_stage.status = wsw_pkg::ST_OK;
        end
        for (int r = 0; r < wsw_pkg::SYN_BITS; r++) begin
            for (int b = 0; b < wsw_pkg::CODE_BITS; b++) begin
                n_stage.rows[r][b] = wsw_pkg::CHECK_ROWS[b][r] & ~i_mask[b];
            end
            n_stage.rows[r][wsw_pkg::TGT_BIT] = w_target[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

[sv/wsw_elim_stage.sv]
// One Gauss-Jordan column step for one cell, skipped when the cell is fixed: pivot search, row swap, elimination.
module wsw_elim_stage #(
    parameter int CELL = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_adv,
    input  wsw_pkg::t_stage i_stage,
    output wsw_pkg::t_stage o_stage
);

    wsw_pkg::t_stage r_stage;
    wsw_pkg::t_stage n_stage;

    logic [wsw_pkg::SYN_BITS-1:0]              w_cand;
    logic [wsw_pkg::ROW_IDX_W-1:0]             w_pv;
    logic [wsw_pkg::ROW_IDX_W-1:0]             w_ci;
    logic [wsw_pkg::ROW_W-1:0]                 w_prow;
    logic [wsw_pkg::SYN_BITS-1:0][wsw_pkg::ROW_W-1:0] w_rows;

    always_comb begin
        w_ci = i_stage.col[wsw_pkg::ROW_IDX_W-1:0];
        w_pv = '0;
        for (int r = 0; r < wsw_pkg::SYN_BITS; r++) begin
            w_cand[r] = i_stage.rows[r][CELL] && (wsw_pkg::COL_W'(r) >= i_stage.col);
        end
        for (int r = wsw_pkg::SYN_BITS - 1; r >= 0; r--) begin
            if (w_cand[r]) begin
                w_pv = wsw_pkg::ROW_IDX_W'(r);
            end
        end
        w_prow = i_stage.rows[w_pv];
        w_rows = i_stage.rows;
        w_rows[w_pv] = i_stage.rows[w_ci];
        w_rows[w_ci] = w_prow;
        for (int r = 0; r < wsw_pkg::SYN_BITS; r++) begin
            if (wsw_pkg::ROW_IDX_W'(r) != w_ci && w_rows[r][CELL]) begin
                w_rows[r] = w_rows[r] ^ w_prow;
            end
        end

        n_stage = i_stage;
        if (i_stage.valid && i_stage.status == wsw_pkg::ST_OK && !i_stage.mask[CELL]) begin
            if (w_cand == '0) begin
                n_stage.status = wsw_pkg::ST_SINGULAR;
            end else begin
                n_stage.rows = w_rows;
                n_stage.col  = i_stage.col + wsw_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else if (i_adv) begin
            r_stage <= n_stage;
        end
    end

    assign o_stage = r_stage;

endmodule

[sv/wsw_extract.sv]
// Output stage: reads the solution from the reduced rows and registers the result.
module wsw_extract (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  wsw_pkg::t_stage               i_stage,
    output logic                          o_valid,
    output logic [wsw_pkg::CODE_BITS-1:0] o_pattern,
    output wsw_pkg::t_status              o_status
);

    logic                          r_valid;
    logic [wsw_pkg::CODE_BITS-1:0] r_pattern;
    wsw_pkg::t_status              r_status;
    logic [wsw_pkg::CODE_BITS-1:0] n_pattern;
    logic [wsw_pkg::CODE_BITS-1:0] w_sol;

    always_comb begin
        w_sol = '0;
        for (int r = 0; r < wsw_pkg::SYN_BITS; r++) begin
            w_sol = w_sol | (i_stage.rows[r][wsw_pkg::CODE_BITS-1:0]
                             & {wsw_pkg::CODE_BITS{i_stage.rows[r][wsw_pkg::TGT_BIT]}});
        end
        if (i_stage.status == wsw_pkg::ST_OK) begin
            n_pattern = i_stage.first | w_sol;
        end else begin
            n_pattern = i_stage.first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid   <= i_stage.valid;
            r_pattern <= n_pattern;
            r_status  <= i_stage.status;
        end
    end

    assign o_valid   = r_valid;
    assign o_pattern = r_pattern;
    assign o_status  = r_status;

endmodule

[sv/wom_second_write_encoder_unit.sv]
// Top level of the WOM coset-code second-write encoder pipeline.
//
//  channel | valid   | stall   | payload
//  --------+---------+---------+-----------------------------------------------
//  input   | i_valid | o_stall | i_value, i_first_pattern, i_fixed_mask
//  output  | o_valid | i_stall | o_second_pattern, o_status
//
// One transaction per cycle while the output is not stalled; the pipeline is a setup stage, one
// elimination stage per cell (22) and the output register.
// The elimination stages set the depth: each handles one column of the system.
// Reset clears the stage valid bits only.
// All stages hold while the output transaction is stalled; nothing is lost.
module wom_second_write_encoder_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_value,
    input  logic [21:0] i_first_pattern,
    input  logic [21:0] i_fixed_mask,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [21:0] o_second_pattern,
    output logic [1:0]  o_status
);

    logic             w_adv;
    wsw_pkg::t_status w_status;
    wsw_pkg::t_stage  w_stage [wsw_pkg::CODE_BITS+1];

    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    wsw_setup u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_valid),
        .i_value (i_value),
        .i_first (i_first_pattern),
        .i_mask  (i_fixed_mask),
        .o_stage (w_stage[0])
    );

    for (genvar g = 0; g < wsw_pkg::CODE_BITS; g++) begin : g_elim
        wsw_elim_stage #(
            .CELL (g)
        ) u_elim (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_stage (w_stage[g]),
            .o_stage (w_stage[g+1])
        );
    end

    wsw_extract u_extract (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_stage   (w_stage[wsw_pkg::CODE_BITS]),
        .o_valid   (o_valid),
        .o_pattern (o_second_pattern),
        .o_status  (w_status)
    );

    assign o_status = w_status;

    a_full_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stage[wsw_pkg::CODE_BITS].valid && w_stage[wsw_pkg::CODE_BITS].status == wsw_pkg::ST_OK
        |-> w_stage[wsw_pkg::CODE_BITS].col == wsw_pkg::COL_W'(wsw_pkg::SYN_BITS))
        else $error("ok transaction left elimination without full rank");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(w_stage[wsw_pkg::CODE_BITS].valid) && $stable(w_stage[0].valid))
        else $error("pipeline moved while output stalled");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a waiting output");

    a_error_keeps_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && w_stage[wsw_pkg::CODE_BITS].valid
        && w_stage[wsw_pkg::CODE_BITS].status != wsw_pkg::ST_OK
        |=> o_second_pattern == $past(w_stage[wsw_pkg::CODE_BITS].first))
        else $error("failed transaction changed the pattern");

endmodule
